// ----- hw/rtl/bgf_pkg.sv -----
// Shared types, constants and helper functions for the biweight gradient filter.
// No dependencies; used by the controller, datapath and top level.
package bgf_pkg;

   localparam int DEF_MAX_ROWS   = 128;
   localparam int DEF_MAX_COLS   = 128;
   localparam int DEF_MAX_RADIUS = 7;

   localparam int CFG_W      = 16;
   localparam int ROWCNT_W   = 8;
   localparam int COLCNT_W   = 8;
   localparam int RADIUS_W   = 3;
   localparam int INVH_W     = 16;

   localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST     = 8'd128;
   localparam logic [COLCNT_W-1:0] COL_COUNT_RST     = 8'd128;
   localparam logic [RADIUS_W-1:0] WINDOW_RADIUS_RST = 3'd7;
   localparam logic [INVH_W-1:0]   INV_H_SQUARED_RST = 16'd1024;

   localparam int PIX_W  = 16;
   localparam int OFS_W  = 5;    // signed window offset, |offset| <= 15
   localparam int MAG_W  = 4;
   localparam int SQ_W   = 8;
   localparam int U_W    = 25;   // 1 - a^2/h^2, signed Q16
   localparam int PU_W   = 2 * U_W;
   localparam int S_W    = 34;   // (1 - b^2/h^2)^2, Q16, non-negative
   localparam int KP_W   = U_W + S_W;
   localparam int K_W    = 43;
   localparam int KLO_W  = 24;
   localparam int KHI_W  = K_W - KLO_W;
   localparam int P_W    = OFS_W + PIX_W;
   localparam int PLO_W  = P_W + KLO_W + 1;
   localparam int PHI_W  = P_W + KHI_W;
   localparam int ACC_W  = 64;
   localparam int OUT_W  = 48;
   localparam int NSTAGE = 8;

   localparam logic signed [U_W-1:0]   Q16_ONE    = 25'sd65536;
   localparam logic signed [ACC_W-1:0] TERM_MAX   = 64'sd4503599627370496;
   localparam logic signed [ACC_W-1:0] TERM_MIN   = -64'sd4503599627370496;
   localparam logic signed [ACC_W-1:0] OUT_MAX    = 64'sd140737488355327;
   localparam logic signed [ACC_W-1:0] OUT_MIN    = -64'sd140737488355328;

   typedef enum logic [1:0] {
      CSR_ROW_COUNT     = 2'd0,
      CSR_COL_COUNT     = 2'd1,
      CSR_WINDOW_RADIUS = 2'd2,
      CSR_INV_H_SQUARED = 2'd3
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef struct packed {
      logic wr_en;
      logic tap_valid;
      logic acc_clear;
      logic finish;
      logic final_pixel;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic out_free;
   } status_type;

   function automatic logic [SQ_W-1:0] square_mag(input logic [MAG_W-1:0] a);
      return SQ_W'(a * a);
   endfunction

endpackage

// ----- hw/rtl/biweight_gradient_filter.sv -----
// Biweight kernel derivative filter, top level: config registers, controller, datapath.
// An item that releases a result passes through accept, divide, setup, address, a walk
// over each window tap (up to 225) and drain; an item that releases no result is only
// accepted, and no new item is taken until drain ends. Throughput is bounded by the single
// tap walk through the pixel store read port. Synchronous reset restores the registers to
// 128 x 128, radius 7, 1/h^2 = 1024, and clears both image positions.
module biweight_gradient_filter #(
   parameter int MAX_ROWS   = bgf_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = bgf_pkg::DEF_MAX_COLS,
   parameter int MAX_RADIUS = bgf_pkg::DEF_MAX_RADIUS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bgf_pkg::PIX_W-1:0]   req_tdata,   // pixel_value
   input  logic                        req_tuser,   // opcode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2*bgf_pkg::OUT_W-1:0] rsp_tdata,   // deriv_x, deriv_y
   output logic                        rsp_tlast,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [bgf_pkg::CFG_W-1:0]   csr_wr_data
);

   localparam int DEPTH  = MAX_ROWS * (2 * MAX_RADIUS + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   logic [bgf_pkg::ROWCNT_W-1:0] row_count_ff;
   logic [bgf_pkg::COLCNT_W-1:0] col_count_ff;
   logic [bgf_pkg::RADIUS_W-1:0] window_radius_ff;
   logic [bgf_pkg::INVH_W-1:0]   inv_h_squared_ff;

   bgf_pkg::cmd_type    cmd;
   bgf_pkg::status_type status;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic signed [bgf_pkg::OFS_W-1:0] tap_i, tap_j;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff     <= bgf_pkg::ROW_COUNT_RST;
         col_count_ff     <= bgf_pkg::COL_COUNT_RST;
         window_radius_ff <= bgf_pkg::WINDOW_RADIUS_RST;
         inv_h_squared_ff <= bgf_pkg::INV_H_SQUARED_RST;
      end else if (csr_wr_en) begin
         case (bgf_pkg::csr_index_type'(csr_index))
            bgf_pkg::CSR_ROW_COUNT:     row_count_ff     <= csr_wr_data[bgf_pkg::ROWCNT_W-1:0];
            bgf_pkg::CSR_COL_COUNT:     col_count_ff     <= csr_wr_data[bgf_pkg::COLCNT_W-1:0];
            bgf_pkg::CSR_WINDOW_RADIUS: window_radius_ff <= csr_wr_data[bgf_pkg::RADIUS_W-1:0];
            bgf_pkg::CSR_INV_H_SQUARED: inv_h_squared_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   bgf_ctrl #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_RADIUS (MAX_RADIUS),
      .DEPTH      (DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tuser     (req_tuser),
      .req_tready    (req_tready),
      .row_count     (row_count_ff),
      .col_count     (col_count_ff),
      .window_radius (window_radius_ff),
      .status        (status),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr),
      .tap_i         (tap_i),
      .tap_j         (tap_j)
   );

   bgf_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr),
      .tap_i         (tap_i),
      .tap_j         (tap_j),
      .pixel         (req_tdata),
      .inv_h_squared (inv_h_squared_ff),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

// ----- hw/rtl/bgf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bgf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1920
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bgf_dp.sv -----
// Datapath: pixel store, kernel and term pipeline, accumulators, result register.
// Depends on bgf_pkg and bgf_ram.
module bgf_dp #(
   parameter int DEPTH = 1920
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bgf_pkg::cmd_type              cmd,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   input  logic signed [bgf_pkg::OFS_W-1:0] tap_i,
   input  logic signed [bgf_pkg::OFS_W-1:0] tap_j,
   input  logic [bgf_pkg::PIX_W-1:0]     pixel,
   input  logic [bgf_pkg::INVH_W-1:0]    inv_h_squared,
   output bgf_pkg::status_type           status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*bgf_pkg::OUT_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast
);

   logic [bgf_pkg::PIX_W-1:0] rd_data;
   logic [bgf_pkg::NSTAGE-1:0] v_ff;

   logic signed [bgf_pkg::OFS_W-1:0] i1_ff, j1_ff;
   logic signed [bgf_pkg::U_W-1:0]   u1i_ff, u1j_ff, u2i_ff, u2j_ff, u3i_ff, u3j_ff;
   logic signed [bgf_pkg::PU_W-1:0]  pui_ff, puj_ff;
   logic signed [bgf_pkg::S_W-1:0]   si_ff, sj_ff;
   logic signed [bgf_pkg::KP_W-1:0]  kxr_ff, kyr_ff;
   logic signed [bgf_pkg::K_W-1:0]   kx_ff, ky_ff;
   logic signed [bgf_pkg::P_W-1:0]   ip_ff [5];
   logic signed [bgf_pkg::P_W-1:0]   jp_ff [5];
   logic signed [bgf_pkg::PLO_W-1:0] plox_ff, ploy_ff;
   logic signed [bgf_pkg::PHI_W-1:0] phix_ff, phiy_ff;
   logic signed [bgf_pkg::ACC_W-1:0] tx_ff, ty_ff;
   logic signed [bgf_pkg::ACC_W-1:0] accx_ff, accy_ff;
   logic                             out_valid_ff;
   logic [bgf_pkg::OUT_W-1:0]        dx_ff, dy_ff;
   logic                             last_ff;

   logic signed [bgf_pkg::PIX_W-1:0] px, pxp;
   logic [bgf_pkg::MAG_W-1:0]        ai, aj;
   logic signed [bgf_pkg::U_W-1:0]   ui_in, uj_in;
   logic signed [bgf_pkg::PU_W-1:0]  pui_r, puj_r;
   logic signed [bgf_pkg::KP_W-1:0]  kxr_r, kyr_r;
   logic signed [bgf_pkg::ACC_W-1:0] tx_in, ty_in, accx_sat, accy_sat;

   bgf_ram #(
      .WIDTH (bgf_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   function automatic logic signed [bgf_pkg::U_W-1:0] one_minus(
      input logic [bgf_pkg::MAG_W-1:0]  a,
      input logic [bgf_pkg::INVH_W-1:0] inv
   );
      logic [bgf_pkg::SQ_W+bgf_pkg::INVH_W-1:0] prod;
      prod = bgf_pkg::square_mag(a) * inv;
      return bgf_pkg::Q16_ONE - $signed({1'b0, prod});
   endfunction

   function automatic logic signed [bgf_pkg::K_W-1:0] round_afz(
      input logic signed [bgf_pkg::KP_W-1:0] v
   );
      logic signed [bgf_pkg::KP_W-1:0] t;
      t = v[bgf_pkg::KP_W-1] ? v + bgf_pkg::KP_W'(32767) : v + bgf_pkg::KP_W'(32768);
      return bgf_pkg::K_W'(t >>> 16);
   endfunction

   function automatic logic signed [bgf_pkg::ACC_W-1:0] sat_term(
      input logic signed [bgf_pkg::PHI_W-1:0] hi,
      input logic signed [bgf_pkg::PLO_W-1:0] lo
   );
      logic signed [bgf_pkg::ACC_W-1:0] t;
      t = (bgf_pkg::ACC_W'(hi) <<< bgf_pkg::KLO_W) + bgf_pkg::ACC_W'(lo);
      if (t > bgf_pkg::TERM_MAX) begin
         t = bgf_pkg::TERM_MAX;
      end else if (t < bgf_pkg::TERM_MIN) begin
         t = bgf_pkg::TERM_MIN;
      end
      return t;
   endfunction

   function automatic logic signed [bgf_pkg::ACC_W-1:0] sat_out(
      input logic signed [bgf_pkg::ACC_W-1:0] v
   );
      logic signed [bgf_pkg::ACC_W-1:0] t;
      t = v;
      if (v > bgf_pkg::OUT_MAX) begin
         t = bgf_pkg::OUT_MAX;
      end else if (v < bgf_pkg::OUT_MIN) begin
         t = bgf_pkg::OUT_MIN;
      end
      return t;
   endfunction

   always_comb begin
      px    = $signed(rd_data);
      pxp   = (px > 0) ? px : '0;
      ai    = bgf_pkg::MAG_W'(i1_ff[bgf_pkg::OFS_W-1] ? -i1_ff : i1_ff);
      aj    = bgf_pkg::MAG_W'(j1_ff[bgf_pkg::OFS_W-1] ? -j1_ff : j1_ff);
      ui_in = one_minus(ai, inv_h_squared);
      uj_in = one_minus(aj, inv_h_squared);
      pui_r = pui_ff + bgf_pkg::PU_W'(32768);
      puj_r = puj_ff + bgf_pkg::PU_W'(32768);
      kxr_r = u3i_ff * sj_ff;
      kyr_r = u3j_ff * si_ff;
      tx_in = sat_term(phix_ff, plox_ff);
      ty_in = sat_term(phiy_ff, ploy_ff);
      accx_sat = sat_out(accx_ff);
      accy_sat = sat_out(accy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         v_ff <= {v_ff[bgf_pkg::NSTAGE-2:0], cmd.tap_valid};
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i1_ff    <= tap_i;
      j1_ff    <= tap_j;
      u1i_ff   <= ui_in;
      u1j_ff   <= uj_in;
      ip_ff[0] <= i1_ff * pxp;
      jp_ff[0] <= j1_ff * pxp;
      pui_ff   <= u1i_ff * u1i_ff;
      puj_ff   <= u1j_ff * u1j_ff;
      u2i_ff   <= u1i_ff;
      u2j_ff   <= u1j_ff;
      si_ff    <= $signed(pui_r[bgf_pkg::PU_W-1:16]);
      sj_ff    <= $signed(puj_r[bgf_pkg::PU_W-1:16]);
      u3i_ff   <= u2i_ff;
      u3j_ff   <= u2j_ff;
      kxr_ff   <= kxr_r;
      kyr_ff   <= kyr_r;
      kx_ff    <= round_afz(kxr_ff);
      ky_ff    <= round_afz(kyr_ff);
      for (int s = 1; s < 5; s++) begin
         ip_ff[s] <= ip_ff[s-1];
         jp_ff[s] <= jp_ff[s-1];
      end
      plox_ff  <= ip_ff[4] * $signed({1'b0, kx_ff[bgf_pkg::KLO_W-1:0]});
      phix_ff  <= ip_ff[4] * $signed(kx_ff[bgf_pkg::K_W-1:bgf_pkg::KLO_W]);
      ploy_ff  <= jp_ff[4] * $signed({1'b0, ky_ff[bgf_pkg::KLO_W-1:0]});
      phiy_ff  <= jp_ff[4] * $signed(ky_ff[bgf_pkg::K_W-1:bgf_pkg::KLO_W]);
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      if (cmd.acc_clear) begin
         accx_ff <= '0;
         accy_ff <= '0;
      end else if (v_ff[bgf_pkg::NSTAGE-1]) begin
         accx_ff <= accx_ff + tx_ff;
         accy_ff <= accy_ff + ty_ff;
      end
      if (cmd.finish) begin
         dx_ff   <= accx_sat[bgf_pkg::OUT_W-1:0];
         dy_ff   <= accy_sat[bgf_pkg::OUT_W-1:0];
         last_ff <= cmd.final_pixel;
      end
   end

   assign status.busy     = |v_ff;
   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = {dy_ff, dx_ff};
   assign rsp_tlast       = last_ff;

endmodule

// ----- hw/rtl/bgf_ctrl.sv -----
// Controller: image positions, window sequencing and result hand-off.
// Depends on bgf_pkg; drives bgf_dp through cmd and reads its status.
module bgf_ctrl #(
   parameter int MAX_ROWS   = bgf_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = bgf_pkg::DEF_MAX_COLS,
   parameter int MAX_RADIUS = bgf_pkg::DEF_MAX_RADIUS,
   parameter int DEPTH      = MAX_ROWS * (2 * MAX_RADIUS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tuser,
   output logic                            req_tready,
   input  logic [bgf_pkg::ROWCNT_W-1:0]    row_count,
   input  logic [bgf_pkg::COLCNT_W-1:0]    col_count,
   input  logic [bgf_pkg::RADIUS_W-1:0]    window_radius,
   input  bgf_pkg::status_type             status,
   output bgf_pkg::cmd_type                cmd,
   output logic [$clog2(DEPTH)-1:0]        wr_addr,
   output logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic signed [bgf_pkg::OFS_W-1:0] tap_i,
   output logic signed [bgf_pkg::OFS_W-1:0] tap_j
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int COL_W  = $clog2(MAX_COLS + 1);
   localparam int POS_W  = $clog2(MAX_ROWS * MAX_COLS + 1);
   localparam int MOD_K  = $clog2((MAX_ROWS * MAX_COLS + DEPTH - 1) / DEPTH);
   localparam int CNT_W  = $clog2(POS_W + MOD_K + 2);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_MOD   = 6'b001000,
      ST_RUN   = 6'b010000,
      ST_DRAIN = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [POS_W-1:0]  in_pos_ff, in_pos_in, out_pos_ff, out_pos_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;
   logic [POS_W-1:0]  quot_ff, quot_in, mod_ff, mod_in;
   logic [ROW_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [bgf_pkg::OFS_W-1:0] i_lo_ff, i_lo_in, i_hi_ff, i_hi_in, j_hi_ff, j_hi_in;
   logic signed [bgf_pkg::OFS_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, cbase_ff, cbase_in;

   logic [ROW_W-1:0]  nrow;
   logic [COL_W-1:0]  ncol;
   logic [bgf_pkg::RADIUS_W-1:0] rad;
   logic [POS_W-1:0]  total;
   logic [31:0]       lag;

   always_comb begin
      if (row_count == '0) begin
         nrow = ROW_W'(1);
      end else if (int'(row_count) > MAX_ROWS) begin
         nrow = ROW_W'(MAX_ROWS);
      end else begin
         nrow = ROW_W'(row_count);
      end
      if (col_count == '0) begin
         ncol = COL_W'(1);
      end else if (int'(col_count) > MAX_COLS) begin
         ncol = COL_W'(MAX_COLS);
      end else begin
         ncol = COL_W'(col_count);
      end
      rad   = (int'(window_radius) > MAX_RADIUS) ? bgf_pkg::RADIUS_W'(MAX_RADIUS)
                                                 : window_radius;
      total = POS_W'(nrow * ncol);
      lag   = 32'(rad) * 32'(nrow) + 32'(rad);
   end

   always_comb begin
      logic [POS_W-1:0]  in_e, out_e, in_n;
      logic [ADDR_W-1:0] wa_e;
      logic              wr, produce, last_row, last_col, fin;
      logic [ROW_W:0]    rem_sh;
      logic [31:0]       sub;
      logic [ADDR_W:0]   a_next, c_next;
      int rp_i, cp_i, rad_i, nr_i, nc_i, r0_i, c0_i;

      state_in  = state_ff;
      in_pos_in = in_pos_ff;
      out_pos_in = out_pos_ff;
      waddr_in  = waddr_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      mod_in    = mod_ff;
      cnt_in    = cnt_ff;
      i_lo_in   = i_lo_ff;
      i_hi_in   = i_hi_ff;
      j_hi_in   = j_hi_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      addr_in   = addr_ff;
      cbase_in  = cbase_ff;
      cmd       = '0;
      req_tready = (state_ff == ST_IDLE);

      if (out_pos_ff >= total) begin
         in_e  = '0;
         out_e = '0;
         wa_e  = '0;
      end else begin
         in_e  = in_pos_ff;
         out_e = out_pos_ff;
         wa_e  = waddr_ff;
      end
      wr      = (req_tuser == bgf_pkg::OP_PIXEL) && (in_e < total);
      in_n    = in_e + POS_W'(wr);
      produce = (in_n >= total) || (32'(in_n) > 32'(out_e) + lag);
      wr_addr = wa_e;

      rem_sh = {rem_ff, quot_ff[POS_W-1]};
      sub    = 32'(DEPTH) << (MOD_K - int'(cnt_ff));
      a_next = {1'b0, addr_ff} + (ADDR_W + 1)'(1);
      c_next = {1'b0, cbase_ff} + (ADDR_W + 1)'(nrow);
      last_row = (i_ff == i_hi_ff);
      last_col = (j_ff == j_hi_ff);
      fin      = (out_pos_ff == total - POS_W'(1));

      rp_i  = int'(rem_ff);
      cp_i  = int'(quot_ff);
      rad_i = int'(rad);
      nr_i  = int'(nrow);
      nc_i  = int'(ncol);
      r0_i  = (rp_i > rad_i) ? rp_i - rad_i : 0;
      c0_i  = (cp_i > rad_i) ? cp_i - rad_i : 0;

      rd_addr = addr_ff;
      tap_i   = i_ff;
      tap_j   = j_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.wr_en  = wr;
               in_pos_in  = in_n;
               out_pos_in = out_e;
               waddr_in   = wr ? ((int'(wa_e) == DEPTH - 1) ? '0 : wa_e + ADDR_W'(1)) : wa_e;
               if (produce) begin
                  quot_in  = out_e;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, nrow}) begin
               rem_in  = ROW_W'(rem_sh - {1'b0, nrow});
               quot_in = {quot_ff[POS_W-2:0], 1'b1};
            end else begin
               rem_in  = ROW_W'(rem_sh);
               quot_in = {quot_ff[POS_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (int'(cnt_ff) == POS_W - 1) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.acc_clear = 1'b1;
            i_lo_in = bgf_pkg::OFS_W'(r0_i - rp_i);
            i_hi_in = bgf_pkg::OFS_W'((rp_i + rad_i < nr_i) ? rad_i : nr_i - 1 - rp_i);
            j_hi_in = bgf_pkg::OFS_W'((cp_i + rad_i < nc_i) ? rad_i : nc_i - 1 - cp_i);
            i_in    = bgf_pkg::OFS_W'(r0_i - rp_i);
            j_in    = bgf_pkg::OFS_W'(c0_i - cp_i);
            mod_in  = POS_W'(nr_i * c0_i + r0_i);
            cnt_in  = '0;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (32'(mod_ff) >= sub) begin
               mod_in = POS_W'(32'(mod_ff) - sub);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (int'(cnt_ff) == MOD_K) begin
               addr_in  = ADDR_W'(mod_in);
               cbase_in = ADDR_W'(mod_in);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.tap_valid = 1'b1;
            if (last_row) begin
               i_in = i_lo_ff;
               j_in = j_ff + bgf_pkg::OFS_W'(1);
               cbase_in = (int'(c_next) >= DEPTH) ? ADDR_W'(int'(c_next) - DEPTH)
                                                  : ADDR_W'(c_next);
               addr_in  = cbase_in;
               if (last_col) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               i_in    = i_ff + bgf_pkg::OFS_W'(1);
               addr_in = (int'(a_next) >= DEPTH) ? '0 : ADDR_W'(a_next);
            end
         end
         ST_DRAIN: begin
            if (!status.busy && status.out_free) begin
               cmd.finish      = 1'b1;
               cmd.final_pixel = fin;
               if (fin) begin
                  in_pos_in  = '0;
                  out_pos_in = '0;
                  waddr_in   = '0;
               end else begin
                  out_pos_in = out_pos_ff + POS_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         waddr_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         in_pos_ff  <= in_pos_in;
         out_pos_ff <= out_pos_in;
         waddr_ff   <= waddr_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      mod_ff   <= mod_in;
      cnt_ff   <= cnt_in;
      i_lo_ff  <= i_lo_in;
      i_hi_ff  <= i_hi_in;
      j_hi_ff  <= j_hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      addr_ff  <= addr_in;
      cbase_ff <= cbase_in;
   end

endmodule
